// ----- rtl/tcfw_pkg.sv -----
package tcfw_pkg;

  // Framebuffer geometry.
  localparam int PIXEL_COLUMNS = 84;
  localparam int PIXEL_BANKS   = 6;
  localparam int TEXT_COLUMNS  = 14;

  // Font cell geometry.
  localparam int GLYPH_WIDTH = 5;
  localparam int CELL_WIDTH  = 6;
  localparam int GLYPH_BITS  = GLYPH_WIDTH * 8;

  localparam int STORE_DEPTH = PIXEL_COLUMNS * PIXEL_BANKS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COPY_BYTES  = (PIXEL_BANKS - 1) * PIXEL_COLUMNS;

  // Width for address and range arithmetic; holds every intermediate sum.
  localparam int CALC_W = $clog2(9 * PIXEL_COLUMNS + 16 * CELL_WIDTH);

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  typedef enum logic [1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_BYTE  = 2'd3
  } tcfw_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new request
    logic cur_upd;     // commit the next cursor position
    logic cnt_clr;     // restart the sweep counter
    logic clr_wr;      // write zero at the sweep counter
    logic scr_step;    // one step of the scroll copy
    logic draw_wr;     // write one glyph column
    logic rd_issue;    // start a framebuffer read
    logic rd_capture;  // take the framebuffer read data
    logic res_load;    // move the finished result to the output register
  } tcfw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    tcfw_op_t op;
    logic     is_newline;
    logic     is_return;
    logic     scroll_need;
    logic     glyph_last;
    logic     sweep_last;
    logic     read_ok;
  } tcfw_status_t;

  // Font: five column bytes per code, the leftmost column in the top byte.
  localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [256] = '{
    40'h0000000000, 40'h3E5B4F5B3E, 40'h3E6B4F6B3E, 40'h1C3E7C3E1C,
    40'h183C7E3C18, 40'h1C577D571C, 40'h1C5E7F5E1C, 40'h00183C1800,
    40'hFFE7C3E7FF, 40'h0018241800, 40'hFFE7DBE7FF, 40'h30483A060E,
    40'h2629792926, 40'h407F050507, 40'h407F05253F, 40'h5A3CE73C5A,
    40'h7F3E1C1C08, 40'h081C1C3E7F, 40'h14227F2214, 40'h5F5F005F5F,
    40'h06097F017F, 40'h006689956A, 40'h6060606060, 40'h94A2FFA294,
    40'h08047E0408, 40'h10207E2010, 40'h08082A1C08, 40'h081C2A0808,
    40'h1E10101010, 40'h0C1E0C1E0C, 40'h30383E3830, 40'h060E3E0E06,
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
    40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
    40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C,
    40'h1EA1A16112, 40'h3A4040207A, 40'h3854545559, 40'h2155557941,
    40'h2254547842, 40'h2155547840, 40'h2054557940, 40'h0C1E527212,
    40'h3955555559, 40'h3954545459, 40'h3955545458, 40'h0000457C41,
    40'h0002457D42, 40'h0001457C40, 40'h7D1211127D, 40'hF0282528F0,
    40'h7C54554500, 40'h2054547C54, 40'h7C0A097F49, 40'h3249494932,
    40'h3A4444443A, 40'h324A484830, 40'h3A4141217A, 40'h3A42402078,
    40'h009DA0A07D, 40'h3D4242423D, 40'h3D4040403D, 40'h3C24FF2424,
    40'h487E494366, 40'h2B2FFC2F2B, 40'hFF0929F620, 40'hC0887E0903,
    40'h2054547941, 40'h0000447D41, 40'h3048484A32, 40'h384040227A,
    40'h007A0A0A72, 40'h7D0D19317D, 40'h2629292F28, 40'h2629292926,
    40'h30484D4020, 40'h3808080808, 40'h0808080838, 40'h2F10C8ACBA,
    40'h2F102834FA, 40'h00007B0000, 40'h08142A1422, 40'h22142A1408,
    40'h5500550055, 40'hAA55AA55AA, 40'hFF55FF55FF, 40'h000000FF00,
    40'h101010FF00, 40'h141414FF00, 40'h1010FF00FF, 40'h1010F010F0,
    40'h141414FC00, 40'h1414F700FF, 40'h0000FF00FF, 40'h1414F404FC,
    40'h141417101F, 40'h10101F101F, 40'h1414141F00, 40'h101010F000,
    40'h0000001F10, 40'h1010101F10, 40'h101010F010, 40'h000000FF10,
    40'h1010101010, 40'h101010FF10, 40'h000000FF14, 40'h0000FF00FF,
    40'h00001F1017, 40'h0000FC04F4, 40'h1414171017, 40'h1414F404F4,
    40'h0000FF00F7, 40'h1414141414, 40'h1414F700F7, 40'h1414141714,
    40'h10101F101F, 40'h141414F414, 40'h1010F010F0, 40'h00001F101F,
    40'h0000001F14, 40'h000000FC14, 40'h0000F010F0, 40'h1010FF10FF,
    40'h141414FF14, 40'h1010101F00, 40'h000000F010, 40'hFFFFFFFFFF,
    40'hF0F0F0F0F0, 40'hFFFFFF0000, 40'h000000FFFF, 40'h0F0F0F0F0F,
    40'h3844443844, 40'hFC4A4A4A34, 40'h7E02020606, 40'h027E027E02,
    40'h6355494163, 40'h3844443C04, 40'h407E201E20, 40'h06027E0202,
    40'h99A5E7A599, 40'h1C2A492A1C, 40'h4C7201724C, 40'h304A4D4D30,
    40'h3048784830, 40'hBC625A463D, 40'h3E49494900, 40'h7E0101017E,
    40'h2A2A2A2A2A, 40'h44445F4444, 40'h40514A4440, 40'h40444A5140,
    40'h0000FF0103, 40'hE080FF0000, 40'h08086B6B08, 40'h3612362436,
    40'h060F090F06, 40'h0000181800, 40'h0000101000, 40'h3040FF0101,
    40'h001F01011E, 40'h00191D1712, 40'h003C3C3C3C, 40'h0000000000
  };

endpackage

// ----- rtl/tcfw_in_if.sv -----
interface tcfw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [3:0] new_column;
  logic [2:0] new_row;
  logic [6:0] read_column;
  logic [2:0] read_bank;

  modport source (
    output valid, opcode, char_code, new_column, new_row, read_column, read_bank,
    input  ready
  );

  modport sink (
    input  valid, opcode, char_code, new_column, new_row, read_column, read_bank,
    output ready
  );
endinterface

// ----- rtl/tcfw_out_if.sv -----
interface tcfw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [3:0] cursor_column;
  logic [2:0] cursor_row;
  logic       scrolled;
  logic       glyph_drawn;

  modport source (
    output valid, read_byte, cursor_column, cursor_row, scrolled, glyph_drawn,
    input  ready
  );

  modport sink (
    input  valid, read_byte, cursor_column, cursor_row, scrolled, glyph_drawn,
    output ready
  );
endinterface

// ----- rtl/tcfw_ram.sv -----
module tcfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcfw_datapath.sv -----
module tcfw_datapath import tcfw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tcfw_cmd_t    cmd,
  output tcfw_status_t stat,
  input  logic [1:0]   item_opcode,
  input  logic [7:0]   item_char_code,
  input  logic [3:0]   item_new_column,
  input  logic [2:0]   item_new_row,
  input  logic [6:0]   item_read_column,
  input  logic [2:0]   item_read_bank,
  output logic [7:0]   res_read_byte,
  output logic [3:0]   res_cursor_column,
  output logic [2:0]   res_cursor_row,
  output logic         res_scrolled,
  output logic         res_glyph_drawn
);

  // Latched request.
  tcfw_op_t              op_r;
  logic [7:0]            code_r;
  logic [3:0]            new_col_r;
  logic [2:0]            new_row_r;
  logic [6:0]            rd_col_r;
  logic [2:0]            rd_bank_r;
  logic [GLYPH_BITS-1:0] glyph_r;

  // Cursor and sweep state.
  logic [3:0]        col_r, col_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [ADDR_W-1:0] cnt_r;

  // Per-request flags.
  logic       drawn_r;
  logic       scrolled_r;
  logic [7:0] rd_byte_r;

  // Scroll write stage, which writes in the cycle after the read of the source byte.
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              wr_zero_r;

  logic [4:0]        col_inc;
  logic [3:0]        row_inc;
  logic              wrap;
  logic              last_row;
  logic              nl_scroll;
  logic [CALC_W-1:0] draw_x;
  logic [CALC_W-1:0] draw_addr;
  logic              draw_ok;
  logic [CALC_W-1:0] read_addr;
  logic [CALC_W-1:0] scroll_src;
  logic              scroll_copy;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign col_inc   = {1'b0, col_r} + 5'd1;
  assign row_inc   = {1'b0, row_r} + 4'd1;
  assign wrap      = CALC_W'(col_inc) >= CALC_W'(TEXT_COLUMNS);
  assign last_row  = CALC_W'(row_r) >= CALC_W'(PIXEL_BANKS - 1);
  assign nl_scroll = CALC_W'(row_inc) > CALC_W'(PIXEL_BANKS - 1);

  assign draw_x    = CALC_W'(col_r) * CALC_W'(CELL_WIDTH) + CALC_W'(cnt_r);
  assign draw_addr = CALC_W'(row_r) * CALC_W'(PIXEL_COLUMNS) + draw_x;
  assign draw_ok   = (CALC_W'(row_r) < CALC_W'(PIXEL_BANKS)) &&
                     (draw_x < CALC_W'(PIXEL_COLUMNS));

  assign read_addr   = CALC_W'(rd_bank_r) * CALC_W'(PIXEL_COLUMNS) + CALC_W'(rd_col_r);
  assign scroll_src  = CALC_W'(cnt_r) + CALC_W'(PIXEL_COLUMNS);
  assign scroll_copy = CALC_W'(cnt_r) < CALC_W'(COPY_BYTES);

  always_comb begin
    stat.op          = op_r;
    stat.is_newline  = (code_r == CODE_NEWLINE);
    stat.is_return   = (code_r == CODE_RETURN);
    stat.scroll_need = stat.is_newline ? nl_scroll : (wrap && last_row);
    stat.glyph_last  = (cnt_r == ADDR_W'(GLYPH_WIDTH - 1));
    stat.sweep_last  = (cnt_r == ADDR_W'(STORE_DEPTH - 1));
    stat.read_ok     = (CALC_W'(rd_col_r) < CALC_W'(PIXEL_COLUMNS)) &&
                       (CALC_W'(rd_bank_r) < CALC_W'(PIXEL_BANKS));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.cur_upd) begin
      case (op_r)
        OP_PUT_CHAR: begin
          if (code_r == CODE_NEWLINE) begin
            row_nxt = nl_scroll ? 3'(PIXEL_BANKS - 1) : row_inc[2:0];
          end else if (code_r == CODE_RETURN) begin
            col_nxt = '0;
          end else begin
            col_nxt = wrap ? 4'd0 : col_inc[3:0];
            if (wrap && !last_row) begin
              row_nxt = row_r + 3'd1;
            end
          end
        end
        OP_SET_CURSOR: begin
          col_nxt = new_col_r;
          row_nxt = new_row_r;
        end
        default: begin
        end
      endcase
    end
  end

  // The scroll write stage owns the write port whenever it is pending.
  always_comb begin
    ram_we    = wr_pend_r | cmd.clr_wr | (cmd.draw_wr & draw_ok);
    ram_waddr = cnt_r;
    ram_wdata = 8'h00;
    if (wr_pend_r) begin
      ram_waddr = wr_addr_r;
      ram_wdata = wr_zero_r ? 8'h00 : ram_rdata;
    end else if (cmd.draw_wr) begin
      ram_waddr = draw_addr[ADDR_W-1:0];
      ram_wdata = glyph_r[GLYPH_BITS-1 -: 8];
    end
    ram_re    = cmd.rd_issue | (cmd.scr_step & scroll_copy);
    ram_raddr = cmd.rd_issue ? read_addr[ADDR_W-1:0] : scroll_src[ADDR_W-1:0];
  end

  tcfw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      cnt_r      <= '0;
      wr_pend_r  <= 1'b0;
      drawn_r    <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      wr_pend_r <= cmd.scr_step;
      if (cmd.load || cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clr_wr || cmd.scr_step || cmd.draw_wr) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.load) begin
        drawn_r    <= 1'b0;
        scrolled_r <= 1'b0;
      end else begin
        if (cmd.draw_wr && draw_ok) begin
          drawn_r <= 1'b1;
        end
        if (cmd.scr_step) begin
          scrolled_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= tcfw_op_t'(item_opcode);
      code_r    <= item_char_code;
      new_col_r <= item_new_column;
      new_row_r <= item_new_row;
      rd_col_r  <= item_read_column;
      rd_bank_r <= item_read_bank;
      glyph_r   <= GLYPH_ROM[item_char_code];
      rd_byte_r <= 8'h00;
    end else begin
      if (cmd.draw_wr) begin
        glyph_r <= glyph_r << 8;
      end
      if (cmd.rd_capture) begin
        rd_byte_r <= ram_rdata;
      end
    end
    wr_addr_r <= cnt_r;
    wr_zero_r <= !scroll_copy;
    if (cmd.res_load) begin
      res_read_byte     <= rd_byte_r;
      res_cursor_column <= col_r;
      res_cursor_row    <= row_r;
      res_scrolled      <= scrolled_r;
      res_glyph_drawn   <= drawn_r;
    end
  end

`ifndef SYNTH
  a_scroll_write_alone: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> !(cmd.clr_wr || cmd.draw_wr))
    else $error("scroll write stage collides with another write");

  a_sweep_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_wr || cmd.scr_step) |-> (cnt_r <= ADDR_W'(STORE_DEPTH - 1)))
    else $error("sweep counter left the framebuffer");

  a_draw_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.draw_wr && draw_ok) |-> (draw_addr < CALC_W'(STORE_DEPTH)))
    else $error("glyph write left the framebuffer");
`endif

endmodule

// ----- rtl/tcfw_controller.sv -----
module tcfw_controller import tcfw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output tcfw_cmd_t    cmd,
  input  tcfw_status_t stat
);

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_DECODE  = 8'b0000_0100,
    ST_DRAW    = 8'b0000_1000,
    ST_SCROLL  = 8'b0001_0000,
    ST_CLEAR   = 8'b0010_0000,
    ST_RD_WAIT = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } tcfw_state_t;

  tcfw_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          OP_PUT_CHAR: begin
            if (stat.is_newline) begin
              cmd.cur_upd = 1'b1;
              state_nxt   = stat.scroll_need ? ST_SCROLL : ST_DONE;
            end else if (stat.is_return) begin
              cmd.cur_upd = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              state_nxt = ST_DRAW;
            end
          end
          OP_SET_CURSOR: begin
            cmd.cur_upd = 1'b1;
            state_nxt   = ST_DONE;
          end
          OP_CLEAR: begin
            state_nxt = ST_CLEAR;
          end
          OP_READ_BYTE: begin
            if (stat.read_ok) begin
              cmd.rd_issue = 1'b1;
              state_nxt    = ST_RD_WAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DRAW: begin
        cmd.draw_wr = 1'b1;
        if (stat.glyph_last) begin
          cmd.cur_upd = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = stat.scroll_need ? ST_SCROLL : ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.scr_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished request");

  a_done_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("finished request overwrote an untaken result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted request was not decoded");
`endif

endmodule

// ----- rtl/text_console_framebuffer_writer_core.sv -----
// Text console writer for an 84 by 6 bank byte framebuffer with a 5x8 font.
// Each request on in_chan is one console operation (put character, set
// cursor, clear, read one byte) and produces exactly one result on out_chan
// with the cursor after the operation, the scrolled and glyph-drawn flags,
// and the byte read (zero for other operations). After reset the block
// clears the framebuffer memory byte by byte and accepts no request until
// that pass is done. The controller walks each operation one memory write
// per cycle: a printable character takes decode, five glyph-column writes
// and the result; carriage return, newline and set cursor take decode and
// the result; an in-range read takes decode, the memory read and the
// result; a clear takes decode, a write per framebuffer byte and the result.
// A newline or line wrap that scrolls adds a pass over the framebuffer, one
// byte copied or blanked per cycle. A new request is accepted while the
// previous result still waits on out_chan; it only stalls at its own result.
module text_console_framebuffer_writer_core import tcfw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  tcfw_in_if.sink    in_chan,
  tcfw_out_if.source out_chan
);

  tcfw_cmd_t    cmd;
  tcfw_status_t stat;

  // The controller sequences every operation and owns both handshakes.
  tcfw_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the cursor, the framebuffer memory, the font table
  // and the result register that feeds out_chan.
  tcfw_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .item_opcode       (in_chan.opcode),
    .item_char_code    (in_chan.char_code),
    .item_new_column   (in_chan.new_column),
    .item_new_row      (in_chan.new_row),
    .item_read_column  (in_chan.read_column),
    .item_read_bank    (in_chan.read_bank),
    .res_read_byte     (out_chan.read_byte),
    .res_cursor_column (out_chan.cursor_column),
    .res_cursor_row    (out_chan.cursor_row),
    .res_scrolled      (out_chan.scrolled),
    .res_glyph_drawn   (out_chan.glyph_drawn)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcfw_pkg::*;

  // The slowest legal run is dominated by scrolls and clears, each a full
  // framebuffer pass, plus long random stalls on both sides. This bound sits
  // far above that and only catches a hung handshake.
  localparam int CYCLE_LIMIT = 3_000_000;

  // One console request as the block sees it on in_chan.
  typedef struct {
    tcfw_op_t   op;
    logic [7:0] char_code;
    logic [3:0] new_column;
    logic [2:0] new_row;
    logic [6:0] read_column;
    logic [2:0] read_bank;
  } console_request_t;

  // One console status word as the block returns it on out_chan.
  typedef struct {
    logic [7:0] read_byte;
    logic [3:0] cursor_column;
    logic [2:0] cursor_row;
    logic       scrolled;
    logic       glyph_drawn;
  } console_status_t;

  logic clk = 1'b0;
  logic rst_n;

  tcfw_in_if  in_chan ();
  tcfw_out_if out_chan ();

  text_console_framebuffer_writer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the console: the framebuffer bytes (bank-major, so the
  // byte of pixel column x in bank b sits at b * PIXEL_COLUMNS + x) and the
  // text cursor. It is advanced once per accepted request, in request order.
  logic [7:0] shadow_frame [STORE_DEPTH];
  logic [3:0] shadow_column;
  logic [2:0] shadow_row;

  // Status words the block still owes us, oldest first.
  console_status_t pending_status [$];

  int error_count;
  int cycle_count;

  // Idle controls, changed between phases. Each is a percentage chance per
  // cycle that the sender holds off or the receiver drops ready.
  int sender_idle_pct;
  int receiver_stall_pct;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Scroll moves every bank up by one over the full width and blanks the
  // bottom bank.
  function automatic void scroll_shadow_frame();
    for (int i = 0; i < COPY_BYTES; i++)
      shadow_frame[i] = shadow_frame[i + PIXEL_COLUMNS];
    for (int i = COPY_BYTES; i < STORE_DEPTH; i++)
      shadow_frame[i] = 8'h00;
  endfunction

  // Applies one console request to the shadow state and returns the status
  // word the block must produce for it.
  function automatic console_status_t predict_console_op(console_request_t req);
    console_status_t         res;
    int                      next_col;
    int                      next_row;
    int                      pix_x;
    logic [GLYPH_BITS-1:0]   glyph_bits;
    res.read_byte   = 8'h00;
    res.scrolled    = 1'b0;
    res.glyph_drawn = 1'b0;
    case (req.op)
      OP_PUT_CHAR: begin
        if (req.char_code == CODE_NEWLINE) begin
          // Newline from the last row, or from the off-screen rows 6 and 7,
          // scrolls and parks the cursor on the last row.
          next_row = int'(shadow_row) + 1;
          if (next_row > PIXEL_BANKS - 1) begin
            scroll_shadow_frame();
            res.scrolled = 1'b1;
            next_row = PIXEL_BANKS - 1;
          end
          shadow_row = 3'(next_row);
        end else if (req.char_code == CODE_RETURN) begin
          shadow_column = 4'd0;
        end else begin
          // Glyph columns that land past the right edge, or anything on an
          // off-screen row, are dropped; the cursor still moves.
          glyph_bits = GLYPH_ROM[req.char_code];
          if (int'(shadow_row) < PIXEL_BANKS) begin
            for (int k = 0; k < GLYPH_WIDTH; k++) begin
              pix_x = int'(shadow_column) * CELL_WIDTH + k;
              if (pix_x < PIXEL_COLUMNS) begin
                shadow_frame[int'(shadow_row) * PIXEL_COLUMNS + pix_x] =
                  8'(glyph_bits >> (8 * (GLYPH_WIDTH - 1 - k)));
                res.glyph_drawn = 1'b1;
              end
            end
          end
          // Wrapping past the last text column either moves down a row or,
          // from the last row and below, scrolls and leaves the row alone.
          next_col = int'(shadow_column) + 1;
          if (next_col >= TEXT_COLUMNS) begin
            next_col = 0;
            if (int'(shadow_row) < PIXEL_BANKS - 1) begin
              shadow_row = shadow_row + 3'd1;
            end else begin
              scroll_shadow_frame();
              res.scrolled = 1'b1;
            end
          end
          shadow_column = 4'(next_col);
        end
      end
      OP_SET_CURSOR: begin
        // Taken as given, no clamping.
        shadow_column = req.new_column;
        shadow_row    = req.new_row;
      end
      OP_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++)
          shadow_frame[i] = 8'h00;
      end
      OP_READ_BYTE: begin
        // Anything outside the buffer reads as zero.
        if (int'(req.read_column) < PIXEL_COLUMNS && int'(req.read_bank) < PIXEL_BANKS)
          res.read_byte =
            shadow_frame[int'(req.read_bank) * PIXEL_COLUMNS + int'(req.read_column)];
      end
      default: ;
    endcase
    res.cursor_column = shadow_column;
    res.cursor_row    = shadow_row;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Sends one request. Before it goes out the sender may sit idle, putting
  // junk on the payload with valid low. The task returns on the step right
  // after the accepting edge with valid still high, so a back-to-back
  // request keeps valid asserted without a low glitch.
  task automatic send_request(console_request_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid       <= 1'b0;
      in_chan.opcode      <= 2'($urandom);
      in_chan.char_code   <= 8'($urandom);
      in_chan.new_column  <= 4'($urandom);
      in_chan.new_row     <= 3'($urandom);
      in_chan.read_column <= 7'($urandom);
      in_chan.read_bank   <= 3'($urandom);
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.opcode      <= req.op;
    in_chan.char_code   <= req.char_code;
    in_chan.new_column  <= req.new_column;
    in_chan.new_row     <= req.new_row;
    in_chan.read_column <= req.read_column;
    in_chan.read_bank   <= req.read_bank;
    // Values read right at the edge are the pre-edge ones, so this sees the
    // same ready the block used to accept.
    do @(posedge clk); while (!in_chan.ready);
    pending_status.push_back(predict_console_op(req));
  endtask

  function automatic console_request_t make_request(tcfw_op_t op, int code, int col,
                                                    int row, int rcol, int rbank);
    console_request_t req;
    req.op          = op;
    req.char_code   = 8'(code);
    req.new_column  = 4'(col);
    req.new_row     = 3'(row);
    req.read_column = 7'(rcol);
    req.read_bank   = 3'(rbank);
    return req;
  endfunction

  task automatic put_char(int code);
    send_request(make_request(OP_PUT_CHAR, code, 0, 0, 0, 0));
  endtask

  task automatic set_cursor(int col, int row);
    send_request(make_request(OP_SET_CURSOR, 0, col, row, 0, 0));
  endtask

  task automatic read_frame_byte(int rcol, int rbank);
    send_request(make_request(OP_READ_BYTE, 0, 0, 0, rcol, rbank));
  endtask

  // Drops valid and holds off until every status word owed has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_status();
    console_status_t want;
    if (pending_status.size() == 0) begin
      report_mismatch("status word arrived with no request outstanding");
    end else begin
      want = pending_status.pop_front();
      if (out_chan.read_byte !== want.read_byte)
        report_mismatch($sformatf("read_byte got %h expected %h",
                                  out_chan.read_byte, want.read_byte));
      if (out_chan.cursor_column !== want.cursor_column)
        report_mismatch($sformatf("cursor_column got %0d expected %0d",
                                  out_chan.cursor_column, want.cursor_column));
      if (out_chan.cursor_row !== want.cursor_row)
        report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                  out_chan.cursor_row, want.cursor_row));
      if (out_chan.scrolled !== want.scrolled)
        report_mismatch($sformatf("scrolled got %b expected %b",
                                  out_chan.scrolled, want.scrolled));
      if (out_chan.glyph_drawn !== want.glyph_drawn)
        report_mismatch($sformatf("glyph_drawn got %b expected %b",
                                  out_chan.glyph_drawn, want.glyph_drawn));
    end
  endtask

  // Receiver: checks each accepted status word, then picks ready for the
  // next cycle. This is the only process that drives out_chan.ready.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        check_status();
      out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog against a stuck handshake.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reads at the corners of the buffer and just outside it, while the
  // buffer is still all zero.
  task automatic test_read_extremes();
    read_frame_byte(0, 0);
    read_frame_byte(PIXEL_COLUMNS - 1, PIXEL_BANKS - 1);
    read_frame_byte(127, 7);
    read_frame_byte(PIXEL_COLUMNS, 0);
    read_frame_byte(0, PIXEL_BANKS);
  endtask

  // Glyph drawing at the extremes of code and cursor: code zero (blank
  // glyph), code 255, the last text column that still fits, a cell that
  // starts past the right edge, and an off-screen row where the wrap from
  // column 15 scrolls while the row stays put.
  task automatic test_glyph_placement();
    put_char(0);
    put_char(255);
    set_cursor(TEXT_COLUMNS - 1, 0);
    put_char(8'h41);
    read_frame_byte((TEXT_COLUMNS - 1) * CELL_WIDTH + GLYPH_WIDTH - 1, 0);
    set_cursor(TEXT_COLUMNS, 2);
    put_char(8'h42);
    set_cursor(15, 7);
    put_char(8'hFF);
    read_frame_byte(0, 0);
  endtask

  // Carriage return and newline, newline from an off-screen row, and a
  // line wrap on the last row that scrolls.
  task automatic test_line_control();
    put_char(CODE_RETURN);
    put_char(CODE_NEWLINE);
    set_cursor(0, 7);
    put_char(CODE_NEWLINE);
    set_cursor(TEXT_COLUMNS - 1, PIXEL_BANKS - 1);
    put_char(8'h5A);
  endtask

  // Clear wipes everything drawn so far.
  task automatic test_clear();
    send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0));
    read_frame_byte((TEXT_COLUMNS - 1) * CELL_WIDTH, 0);
  endtask

  // Mostly console-like traffic: text with line control, occasional cursor
  // moves and readback, rare clears. A minority of requests pokes at
  // out-of-range cursors and reads. Fields an op ignores carry random bits.
  function automatic console_request_t random_console_request();
    console_request_t req;
    int               pick;
    pick            = $urandom_range(99);
    req.char_code   = 8'($urandom);
    req.new_column  = 4'($urandom);
    req.new_row     = 3'($urandom);
    req.read_column = 7'($urandom);
    req.read_bank   = 3'($urandom);
    if (pick < 60) begin
      req.op = OP_PUT_CHAR;
      pick   = $urandom_range(99);
      if (pick < 8)
        req.char_code = CODE_NEWLINE;
      else if (pick < 12)
        req.char_code = CODE_RETURN;
    end else if (pick < 70) begin
      req.op = OP_SET_CURSOR;
      if ($urandom_range(99) < 80) begin
        req.new_column = 4'($urandom_range(TEXT_COLUMNS - 1));
        req.new_row    = 3'($urandom_range(PIXEL_BANKS - 1));
      end
    end else if (pick < 99) begin
      req.op = OP_READ_BYTE;
      if ($urandom_range(99) < 85) begin
        req.read_column = 7'($urandom_range(PIXEL_COLUMNS - 1));
        req.read_bank   = 3'($urandom_range(PIXEL_BANKS - 1));
      end
    end else begin
      req.op = OP_CLEAR;
    end
    return req;
  endfunction

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count)
      send_request(random_console_request());
    // Let the block go fully quiet between phases.
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    error_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    shadow_column      = 4'd0;
    shadow_row         = 3'd0;
    for (int i = 0; i < STORE_DEPTH; i++)
      shadow_frame[i] = 8'h00;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.opcode      <= OP_PUT_CHAR;
    in_chan.char_code   <= 8'h00;
    in_chan.new_column  <= 4'd0;
    in_chan.new_row     <= 3'd0;
    in_chan.read_column <= 7'd0;
    in_chan.read_bank   <= 3'd0;
    repeat (7) @(posedge clk);
    // The block clears its memory for a while after this; the first request
    // simply waits on ready.
    rst_n <= 1'b1;

    test_read_extremes();
    test_glyph_placement();
    test_line_control();
    test_clear();
    drain_results();

    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 81, 0);
    test_random_traffic(200, 0, 81);
    test_random_traffic(200, 22, 22);

    // Wait quietly so any stray extra status word gets caught.
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
